/* hw/rtl/srs_pkg.sv */
// shared types and constants of the stereo linear resampler
package srs_pkg;

    localparam int FRAC_BITS = 16;
    localparam int MAX_RUN   = 16;
    localparam int SAMPLE_W  = 16;
    localparam int STEP_W    = 20;
    // running phase needs one bit more than the stored step
    localparam int PHASE_W   = STEP_W + 1;
    localparam int CNT_W     = $clog2(MAX_RUN + 1);
    localparam int DIFF_W    = SAMPLE_W + 1;
    localparam int PROD_W    = DIFF_W + FRAC_BITS + 1;

    localparam logic [PHASE_W-1:0] PHASE_ONE  = PHASE_W'(1) << FRAC_BITS;
    localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(65536);

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
        logic                       last_of_run;
    } t_out_item;

    typedef struct packed {
        logic valid;
        logic last;
    } t_stage_ctl;

endpackage

/* hw/rtl/srs_lerp_lane.sv */
// one channel lane: registered product, then older plus scaled difference
module srs_lerp_lane (
    input  logic                                    i_clk,
    input  logic                                    i_advance,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]     i_older,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]     i_newer,
    input  logic        [srs_pkg::FRAC_BITS-1:0]    i_frac,
    output logic signed [srs_pkg::SAMPLE_W-1:0]     o_result
);
    import srs_pkg::*;

    logic signed [DIFF_W-1:0]    diff;
    logic signed [FRAC_BITS:0]   frac_s;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [SAMPLE_W-1:0]  r_older;

    assign diff   = DIFF_W'(i_newer) - DIFF_W'(i_older);
    assign frac_s = {1'b0, i_frac};

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_prod  <= diff * frac_s;
            r_older <= i_older;
        end
    end

    // arithmetic shift is a floor; only the low sample bits survive the wrap
    assign o_result = r_older + r_prod[FRAC_BITS+SAMPLE_W-1:FRAC_BITS];

endmodule

/* hw/rtl/srs_merge.sv */
// output register that joins both lane results into one item
module srs_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  srs_pkg::t_stage_ctl                  i_ctl,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]  i_left,
    input  logic signed [srs_pkg::SAMPLE_W-1:0]  i_right,
    input  logic                                 i_out_ready,
    output logic                                 o_out_valid,
    output srs_pkg::t_out_item                   o_out,
    output logic                                 o_advance
);
    import srs_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_advance = !r_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_ctl.valid) begin
            r_item.left_out    <= i_left;
            r_item.right_out   <= i_right;
            r_item.last_of_run <= i_ctl.last;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out       = r_item;

endmodule

/* hw/rtl/stereo_linear_resampler_core.sv */
// top level of the stereo linear-interpolation sample-rate converter
//
//  channel   direction  handshake                   payload
//  in        to block   i_in_valid / o_in_ready     i_in  (left_sample, right_sample)
//  out       from block o_out_valid / i_out_ready   o_out (left_out, right_out, last_of_run)
//  cfg       to block   i_cfg_we                    i_cfg_data (phase_step)
//
//  the block takes an item on the handshake, issues its n results (0 to MAX_RUN) one a cycle
//  while the output is not stalled, and takes the next item on the cycle after its last issue
//  each result passes the lane product register, then the output register, on its way to o_out
//  an item with no result shifts the history and drops the phase by 1.0; the block stays idle
//  a stalled output holds the whole lane pipeline and a busy issue sequencer in place
//  synchronous active-low reset clears history, phase and control; step returns to 1.0
module stereo_linear_resampler_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  srs_pkg::t_in_item                  i_in,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output srs_pkg::t_out_item                 o_out,
    input  logic                               i_cfg_we,
    input  logic [srs_pkg::STEP_W-1:0]         i_cfg_data
);
    import srs_pkg::*;

    // configuration
    logic [STEP_W-1:0] r_phase_step;

    // two-deep sample history
    logic signed [SAMPLE_W-1:0] r_older_l, r_older_r;
    logic signed [SAMPLE_W-1:0] r_newer_l, r_newer_r;

    // issue sequencer
    logic               r_busy,  n_busy;
    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;

    // tag travelling alongside the lane product registers
    t_stage_ctl r_ctl_b;

    logic               in_acc;
    logic               adv;
    logic               iss;
    logic               iss_last;
    logic [PHASE_W-1:0] phase_sum;
    logic               sum_ge;
    logic               at_max;
    logic signed [SAMPLE_W-1:0] lane_l, lane_r;

    assign o_in_ready = !r_busy;
    assign in_acc     = i_in_valid && o_in_ready;

    // next phase after this output and whether the run ends here
    assign phase_sum = r_phase + {1'b0, r_phase_step};
    assign sum_ge    = phase_sum >= PHASE_ONE;
    assign at_max    = r_count == CNT_W'(MAX_RUN - 1);
    assign iss       = r_busy && adv;
    assign iss_last  = sum_ge || at_max;

    always_comb begin
        n_busy  = r_busy;
        n_phase = r_phase;
        n_count = r_count;
        if (in_acc) begin
            if (r_phase >= PHASE_ONE) begin
                // phase already past this input: no output
                n_phase = r_phase - PHASE_ONE;
            end else begin
                n_busy  = 1'b1;
                n_count = '0;
            end
        end else if (iss) begin
            if (iss_last) begin
                n_busy = 1'b0;
                // run cut at the limit clears the phase instead of dropping 1.0
                n_phase = sum_ge ? (phase_sum - PHASE_ONE) : '0;
            end else begin
                n_phase = phase_sum;
                n_count = r_count + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= STEP_RESET;
            r_busy       <= 1'b0;
            r_phase      <= '0;
            r_count      <= '0;
            r_older_l    <= '0;
            r_older_r    <= '0;
            r_newer_l    <= '0;
            r_newer_r    <= '0;
            r_ctl_b      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_phase_step <= i_cfg_data;
            end
            r_busy  <= n_busy;
            r_phase <= n_phase;
            r_count <= n_count;
            if (in_acc) begin
                r_older_l <= r_newer_l;
                r_older_r <= r_newer_r;
                r_newer_l <= i_in.left_sample;
                r_newer_r <= i_in.right_sample;
            end
            if (adv) begin
                r_ctl_b.valid <= iss;
                r_ctl_b.last  <= iss_last;
            end
        end
    end

    // one lane per channel, both fed the same phase fraction
    srs_lerp_lane u_lane_l (
        .i_clk     (i_clk),
        .i_advance (adv),
        .i_older   (r_older_l),
        .i_newer   (r_newer_l),
        .i_frac    (r_phase[FRAC_BITS-1:0]),
        .o_result  (lane_l)
    );

    srs_lerp_lane u_lane_r (
        .i_clk     (i_clk),
        .i_advance (adv),
        .i_older   (r_older_r),
        .i_newer   (r_newer_r),
        .i_frac    (r_phase[FRAC_BITS-1:0]),
        .o_result  (lane_r)
    );

    srs_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (r_ctl_b),
        .i_left      (lane_l),
        .i_right     (lane_r),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_out       (o_out),
        .o_advance   (adv)
    );

`ifndef SYNTH
    // stored phase between items always fits the step width
    a_phase_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> !r_phase[PHASE_W-1])
        else $error("idle phase out of range");

    // issuing the last output of a run frees the sequencer
    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (iss && iss_last) |=> !r_busy)
        else $error("sequencer still busy after last issue");

    // run length never passes the limit
    a_run_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_count <= CNT_W'(MAX_RUN - 1)))
        else $error("run count beyond limit");
`endif

endmodule
